// ----- design/assert_macros.svh -----
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/msbp_pkg.sv -----
package msbp_pkg;

  localparam int unsigned BTB_ENTRIES_DEF         = 1024;
  localparam int unsigned GLOBAL_HISTORY_BITS_DEF = 8;
  localparam int unsigned LOCAL_HISTORY_BITS_DEF  = 12;
  localparam int unsigned PATTERN_ENTRIES_DEF     = 4096;
  localparam int unsigned ADDRESS_BITS_DEF        = 48;

  localparam int unsigned MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_ONE_BIT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TWO_BIT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GAG     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PAG     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HYBRID  = 3'd4;

  localparam logic [1:0] CTR_WEAK_NT = 2'd1;
  localparam logic [1:0] CTR_WEAK_T  = 2'd2;
  localparam logic [1:0] CTR_MAX     = 2'd3;
  localparam logic [1:0] CTR_MIN     = 2'd0;

  typedef enum logic [3:0] {
    ST_CLEAR   = 4'b0001,
    ST_IDLE    = 4'b0010,
    ST_READ    = 4'b0100,
    ST_RESOLVE = 4'b1000
  } state_e;

  function automatic logic [1:0] sat_step(logic [1:0] c, logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

// ----- design/msbp_if.sv -----
interface msbp_branch_if #(
  parameter int unsigned ADDRESS_BITS = 48
);
  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] branch_address;
  logic                    branch_taken;

  modport source (output valid, output branch_address, output branch_taken, input ready);
  modport sink   (input valid, input branch_address, input branch_taken, output ready);
endinterface

interface msbp_result_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  logic btb_hit;
  logic prediction_correct;
  logic entry_replaced;

  modport source (output valid, output predicted_taken, output btb_hit,
                  output prediction_correct, output entry_replaced, input ready);
  modport sink   (input valid, input predicted_taken, input btb_hit,
                  input prediction_correct, input entry_replaced, output ready);
endinterface

// ----- design/multi_scheme_branch_predictor_core.sv -----
// channel    | dir | handshake    | word
// branch_i   | in  | valid/ready  | branch_address, branch_taken
// result_o   | out | valid/ready  | predicted_taken, btb_hit, prediction_correct, entry_replaced
// cfg        | in  | cfg_we_i     | cfg_wdata_i (prediction mode)
//
// each word goes through btb memory read, pattern memory read, then resolve and write back
// a new word is taken only after the previous word has been resolved
// after reset a clearing pass over max(BTB_ENTRIES, PATTERN_ENTRIES) addresses fills both memories
// no word is taken during the clearing pass; cfg writes are taken at any time
// a result waiting in the output register holds the resolve step until it is taken
module multi_scheme_branch_predictor_core
  import msbp_pkg::*;
#(
  parameter int unsigned BTB_ENTRIES         = BTB_ENTRIES_DEF,
  parameter int unsigned GLOBAL_HISTORY_BITS = GLOBAL_HISTORY_BITS_DEF,
  parameter int unsigned LOCAL_HISTORY_BITS  = LOCAL_HISTORY_BITS_DEF,
  parameter int unsigned PATTERN_ENTRIES     = PATTERN_ENTRIES_DEF,
  parameter int unsigned ADDRESS_BITS        = ADDRESS_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  msbp_branch_if.sink       branch_i,
  msbp_result_if.source     result_o
);

  localparam int unsigned BTB_IW    = $clog2(BTB_ENTRIES);
  localparam int unsigned PAT_IW    = $clog2(PATTERN_ENTRIES);
  localparam int unsigned CLR_DEPTH = (BTB_ENTRIES > PATTERN_ENTRIES) ?
                                      BTB_ENTRIES : PATTERN_ENTRIES;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
  localparam int unsigned GH_W      = GLOBAL_HISTORY_BITS;
  localparam int unsigned LH_W      = LOCAL_HISTORY_BITS;

  typedef struct packed {
    logic                    valid;
    logic [ADDRESS_BITS-1:0] tag;
    logic                    last;
    logic [1:0]              ctr;
    logic [LH_W-1:0]         lhist;
  } btb_entry_t;

  btb_entry_t btb_mem [BTB_ENTRIES];
  logic [1:0] pat_mem [PATTERN_ENTRIES];

  state_e state_q, state_d;
  logic [CLR_W-1:0]        clr_q, clr_d;
  logic [MODE_W-1:0]       mode_q;
  logic [GH_W-1:0]         gh_q, gh_d;
  logic [1:0]              ch_q, ch_d;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic                    taken_q;
  btb_entry_t              btb_rd_q;
  logic [1:0]              pat_rd_q;
  logic [PAT_IW-1:0]       pidx_q, pidx_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_pred_q, out_hit_q, out_corr_q, out_repl_q;

  logic              accept, finish, clearing;
  logic              btb_we, pat_we;
  logic [BTB_IW-1:0] btb_wa, idx;
  logic [PAT_IW-1:0] pat_wa, res_pat_wa;
  btb_entry_t        btb_wd, e_new;
  logic [1:0]        pat_wd, res_pat_wd;
  logic              res_btb_we, res_pat_we;
  logic              hit, pred, repl;

  assign clearing       = (state_q == ST_CLEAR);
  assign branch_i.ready = (state_q == ST_IDLE);
  assign accept         = branch_i.valid && branch_i.ready;
  assign finish         = (state_q == ST_RESOLVE) && (!out_valid_q || result_o.ready);
  assign idx            = addr_q[BTB_IW-1:0];
  assign hit            = btb_rd_q.valid && (btb_rd_q.tag == addr_q);

  // pattern index for the read step
  always_comb begin
    if (mode_q == MODE_PAG) begin
      pidx_d = PAT_IW'(btb_rd_q.lhist);
    end else begin
      pidx_d = PAT_IW'(gh_q);
    end
  end

  // resolve step
  always_comb begin
    e_new      = btb_rd_q;
    res_btb_we = 1'b0;
    res_pat_we = 1'b0;
    res_pat_wa = pidx_q;
    res_pat_wd = pat_rd_q;
    gh_d       = gh_q;
    ch_d       = ch_q;
    pred       = 1'b0;
    repl       = 1'b0;
    if (hit) begin
      case (mode_q)
        MODE_TWO_BIT: begin
          pred       = btb_rd_q.ctr[1];
          e_new.ctr  = sat_step(btb_rd_q.ctr, taken_q);
          res_btb_we = 1'b1;
        end
        MODE_GAG: begin
          pred       = pat_rd_q[1];
          res_pat_wd = sat_step(pat_rd_q, taken_q);
          res_pat_we = 1'b1;
          gh_d       = {gh_q[GH_W-2:0], taken_q};
        end
        MODE_PAG: begin
          pred        = pat_rd_q[1];
          res_pat_wd  = sat_step(pat_rd_q, taken_q);
          res_pat_we  = 1'b1;
          e_new.lhist = {btb_rd_q.lhist[LH_W-2:0], taken_q};
          res_btb_we  = 1'b1;
        end
        MODE_HYBRID: begin
          if (ch_q[1]) begin
            pred       = pat_rd_q[1];
            res_pat_wd = sat_step(pat_rd_q, taken_q);
            res_pat_we = 1'b1;
            gh_d       = {gh_q[GH_W-2:0], taken_q};
          end else begin
            pred       = btb_rd_q.ctr[1];
            e_new.ctr  = sat_step(btb_rd_q.ctr, taken_q);
            res_btb_we = 1'b1;
          end
          ch_d = sat_step(ch_q, taken_q);
        end
        default: begin
          pred       = btb_rd_q.last;
          e_new.last = taken_q;
          res_btb_we = 1'b1;
        end
      endcase
    end else if (!taken_q) begin
      if ((mode_q == MODE_GAG) || (mode_q == MODE_HYBRID)) begin
        gh_d       = {gh_q[GH_W-2:0], 1'b0};
        res_pat_we = 1'b1;
        res_pat_wa = PAT_IW'(gh_d);
        res_pat_wd = CTR_WEAK_NT;
      end
    end else begin
      repl        = btb_rd_q.valid;
      e_new.valid = 1'b1;
      e_new.tag   = addr_q;
      res_btb_we  = 1'b1;
      case (mode_q)
        MODE_TWO_BIT: begin
          e_new.ctr = CTR_WEAK_T;
        end
        MODE_GAG: begin
          gh_d = {gh_q[GH_W-2:0], 1'b1};
        end
        MODE_PAG: begin
          e_new.lhist = LH_W'(1);
          res_pat_we  = 1'b1;
          res_pat_wa  = PAT_IW'(1);
          res_pat_wd  = CTR_WEAK_T;
        end
        MODE_HYBRID: begin
          e_new.ctr  = CTR_WEAK_T;
          gh_d       = {gh_q[GH_W-2:0], 1'b1};
          res_pat_we = 1'b1;
          res_pat_wa = PAT_IW'(gh_d);
          res_pat_wd = CTR_WEAK_T;
        end
        default: begin
          e_new.last = 1'b1;
        end
      endcase
    end
  end

  // memory write ports, shared with the clearing pass
  always_comb begin
    if (clearing) begin
      btb_we       = 1'b1;
      btb_wa       = clr_q[BTB_IW-1:0];
      btb_wd       = btb_rd_q;
      btb_wd.valid = 1'b0;
      btb_wd.tag   = '0;
      btb_wd.last  = 1'b0;
      btb_wd.ctr   = CTR_WEAK_NT;
      btb_wd.lhist = '0;
      pat_we       = 1'b1;
      pat_wa       = clr_q[PAT_IW-1:0];
      pat_wd       = CTR_WEAK_T;
    end else begin
      btb_we = finish && res_btb_we;
      btb_wa = idx;
      btb_wd = e_new;
      pat_we = finish && res_pat_we;
      pat_wa = res_pat_wa;
      pat_wd = res_pat_wd;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (btb_we) begin
      btb_mem[btb_wa] <= btb_wd;
    end
    if (accept) begin
      btb_rd_q <= btb_mem[branch_i.branch_address[BTB_IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_wa] <= pat_wd;
    end
    if (state_q == ST_READ) begin
      pat_rd_q <= pat_mem[pidx_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= branch_i.branch_address;
      taken_q <= branch_i.branch_taken;
    end
    if (state_q == ST_READ) begin
      pidx_q <= pidx_d;
    end
    if (finish) begin
      out_pred_q <= pred;
      out_hit_q  <= hit;
      out_corr_q <= (pred == taken_q);
      out_repl_q <= repl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      mode_q      <= MODE_ONE_BIT;
      gh_q        <= '0;
      ch_q        <= CTR_WEAK_T;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (finish) begin
        gh_q <= gh_d;
        ch_q <= ch_d;
      end
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.predicted_taken    = out_pred_q;
  assign result_o.btb_hit            = out_hit_q;
  assign result_o.prediction_correct = out_corr_q;
  assign result_o.entry_replaced     = out_repl_q;

endmodule

// ----- design/msbp_checker.sv -----
`include "assert_macros.svh"

module msbp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_pred_i,
  input logic out_hit_i,
  input logic out_repl_i
);

  // one word in flight at a time
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "word accepted while busy")

  // a miss always predicts not taken
  `ASSERT_SAME(a_miss_not_taken, clk_i, rst_ni, out_valid_i && !out_hit_i, !out_pred_i, "miss predicted taken")

  // eviction only on a miss
  `ASSERT_SAME(a_repl_on_miss, clk_i, rst_ni, out_valid_i && out_repl_i, !out_hit_i, "replacement on a hit")

  // a stalled result stays
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

endmodule

bind multi_scheme_branch_predictor_core msbp_checker u_msbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (branch_i.valid),
  .in_ready_i  (branch_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_pred_i  (result_o.predicted_taken),
  .out_hit_i   (result_o.btb_hit),
  .out_repl_i  (result_o.entry_replaced)
);
